>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the ranker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define TFPR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TFPR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/tfpr_pkg.sv
// Shared types, constants and helper functions of the tiered fuzzy path ranker.
package tfpr_pkg;

   // Default sizing
   localparam int MAX_PATTERN_DEF = 16;
   localparam int LENGTH_CAP_DEF  = 4096;

   // Fixed field widths
   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_W     = 8 * PATTERN_BYTES;
   localparam int POS_W         = 16;
   localparam int FUZZY_W       = 18;
   localparam int SCORE_W       = 23;
   localparam int TIER_W        = 3;
   localparam int LEN_W         = 5;
   localparam int IDX_W         = 7;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;
   localparam int TIER_STEP     = 1000000;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_PATTERN_LENGTH = 2'd2
   } csr_reg_type;

   // Rank tiers
   typedef enum logic [TIER_W-1:0] {
      TIER_NONE        = 3'd0,
      TIER_SUBSEQUENCE = 3'd1,
      TIER_PATH_SUB    = 3'd2,
      TIER_BASE_SUB    = 3'd3,
      TIER_BASE_PREFIX = 3'd4,
      TIER_BASE_EXACT  = 3'd5
   } tier_type;

   // One result of the ranker
   typedef struct packed {
      logic                 matched;
      tier_type             tier;
      logic [SCORE_W-1:0]   score;
   } result_type;

   // Fold ASCII capitals to lower case
   function automatic logic [7:0] lower_byte(input logic [7:0] c);
      if (c inside {[8'h41:8'h5A]}) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Pattern byte at a given index; bytes past the stored pattern read as zero
   function automatic logic [7:0] pattern_byte(input logic [PATTERN_W-1:0] pat,
                                               input logic [IDX_W-1:0] idx);
      if (idx < IDX_W'(PATTERN_BYTES)) begin
         return pat[idx[3:0] * 8 +: 8];
      end
      return 8'h00;
   endfunction

   // Score offset of a tier
   function automatic logic [SCORE_W-1:0] tier_base(input tier_type t);
      case (t)
         TIER_SUBSEQUENCE: return SCORE_W'(1 * TIER_STEP);
         TIER_PATH_SUB:    return SCORE_W'(2 * TIER_STEP);
         TIER_BASE_SUB:    return SCORE_W'(3 * TIER_STEP);
         TIER_BASE_PREFIX: return SCORE_W'(4 * TIER_STEP);
         TIER_BASE_EXACT:  return SCORE_W'(5 * TIER_STEP);
         default:          return '0;
      endcase
   endfunction

endpackage

>>> hdl/tfpr_cell.sv
// One cell of the shift-and substring row: holds one bit of the match vector.
module tfpr_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       clear,
   input  logic       enable,
   input  logic       tail,
   input  logic       shift_in,
   input  logic [7:0] pat_char,
   input  logic [7:0] path_char,
   output logic       shift_out,
   output logic       hit
);

   logic vec_ff;
   logic vec_in;

   // Extend the partial match from the left neighbour when this byte agrees
   assign vec_in = shift_in & enable & (path_char == pat_char);

   // The cell at the pattern's last byte reports a full occurrence
   assign hit       = tail & vec_in;
   assign shift_out = vec_ff;

   // Advance on each request, drop the state after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff <= 1'b0;
      end else if (advance) begin
         vec_ff <= clear ? 1'b0 : vec_in;
      end
   end

endmodule

>>> hdl/tfpr_scorer.sv
// Greedy subsequence scorer, position tracking, hit flags and result ranking.
module tfpr_scorer #(
   parameter int MAX_PATTERN = tfpr_pkg::MAX_PATTERN_DEF,
   parameter int LENGTH_CAP  = tfpr_pkg::LENGTH_CAP_DEF,
   localparam int CUR_W      = $clog2(MAX_PATTERN + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              last,
   input  logic [7:0]                        path_char,
   input  logic [tfpr_pkg::POS_W-1:0]        basename_start,
   input  logic [tfpr_pkg::PATTERN_W-1:0]    pattern,
   input  logic [CUR_W-1:0]                  pat_len,
   input  logic                              sub_hit,
   output tfpr_pkg::result_type              result
);

   localparam int W18 = tfpr_pkg::POS_W + 2;
   localparam int SW  = tfpr_pkg::SCORE_W + 2;

   logic [CUR_W-1:0]                      cursor_ff, cursor_in;
   logic signed [tfpr_pkg::FUZZY_W-1:0]   fuzzy_ff, fuzzy_in;
   logic                                  have_ff, have_in;
   logic                                  prev_match_ff, prev_match_in;
   logic                                  gap_ff, gap_in;
   logic [7:0]                            prev_byte_ff;
   logic [tfpr_pkg::POS_W-1:0]            pos_ff, pos_in;
   logic [2:0]                            hits_ff, hits_in;

   logic                                  active;
   logic                                  char_match;
   logic                                  boundary;
   logic signed [6:0]                     delta;
   logic signed [tfpr_pkg::FUZZY_W:0]     fuzzy_sum;
   logic [W18-1:0]                        end_pos;
   logic [W18-1:0]                        base_end;
   logic [W18-1:0]                        path_len;
   logic [tfpr_pkg::FUZZY_W-2:0]          fuzzy_floor;
   logic [tfpr_pkg::POS_W-1:0]            len_capped;
   logic [SW-1:0]                         score_wide;
   tfpr_pkg::tier_type                    tier;

   assign active     = (pat_len != '0) && (cursor_ff < pat_len);
   assign char_match = path_char ==
                       tfpr_pkg::pattern_byte(pattern, tfpr_pkg::IDX_W'(cursor_ff));
   assign boundary   = (pos_ff == '0) ||
                       (prev_byte_ff inside {8'h2F, 8'h5F, 8'h2D, 8'h2E, 8'h20});

   // Weight of this byte in the subsequence score
   always_comb begin
      delta = '0;
      if (active) begin
         if (char_match) begin
            delta = 7'sd16;
            if (boundary) begin
               delta = delta + 7'sd8;
            end
            if ((cursor_ff == '0) && (pos_ff >= basename_start)) begin
               delta = delta + 7'sd8;
            end
            if (have_ff && prev_match_ff) begin
               delta = delta + 7'sd4;
            end
         end else if (have_ff) begin
            delta = gap_ff ? -7'sd1 : -7'sd3;
         end
      end
   end

   // Fuzzy sum, saturating at the bottom
   assign fuzzy_sum = {fuzzy_ff[tfpr_pkg::FUZZY_W-1], fuzzy_ff} +
                      (tfpr_pkg::FUZZY_W + 1)'(delta);
   always_comb begin
      if (fuzzy_sum < -(tfpr_pkg::FUZZY_W + 1)'(131072)) begin
         fuzzy_in = {1'b1, {(tfpr_pkg::FUZZY_W - 1){1'b0}}};
      end else begin
         fuzzy_in = fuzzy_sum[tfpr_pkg::FUZZY_W-1:0];
      end
   end

   // Subsequence control state
   always_comb begin
      cursor_in     = cursor_ff;
      have_in       = have_ff;
      prev_match_in = prev_match_ff;
      gap_in        = gap_ff;
      if (active) begin
         if (char_match) begin
            cursor_in     = cursor_ff + CUR_W'(1);
            have_in       = 1'b1;
            prev_match_in = 1'b1;
            gap_in        = 1'b0;
         end else begin
            gap_in        = have_ff | gap_ff;
            prev_match_in = 1'b0;
         end
      end
   end

   // Saturating position and substring hit flags
   assign pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + tfpr_pkg::POS_W'(1);
   assign end_pos  = W18'(pos_ff) + W18'(1);
   assign base_end = W18'(basename_start) + W18'(pat_len);
   assign path_len = W18'(pos_in);

   always_comb begin
      hits_in = hits_ff;
      if (sub_hit) begin
         hits_in[0] = 1'b1;
         if (end_pos >= base_end) begin
            hits_in[1] = 1'b1;
         end
         if (end_pos == base_end) begin
            hits_in[2] = 1'b1;
         end
      end
   end

   // Rank the finished path
   always_comb begin
      if (hits_in[2] && (path_len == base_end)) begin
         tier = tfpr_pkg::TIER_BASE_EXACT;
      end else if (hits_in[2]) begin
         tier = tfpr_pkg::TIER_BASE_PREFIX;
      end else if (hits_in[1]) begin
         tier = tfpr_pkg::TIER_BASE_SUB;
      end else if (hits_in[0]) begin
         tier = tfpr_pkg::TIER_PATH_SUB;
      end else begin
         tier = tfpr_pkg::TIER_SUBSEQUENCE;
      end
   end

   assign fuzzy_floor = (fuzzy_in < tfpr_pkg::FUZZY_W'(1)) ? (tfpr_pkg::FUZZY_W - 1)'(1)
                                                          : fuzzy_in[tfpr_pkg::FUZZY_W-2:0];
   assign len_capped  = (pos_in > tfpr_pkg::POS_W'(LENGTH_CAP))
                        ? tfpr_pkg::POS_W'(LENGTH_CAP) : pos_in;
   assign score_wide  = SW'(tfpr_pkg::tier_base(tier)) + SW'({fuzzy_floor, 3'b000})
                        - SW'(len_capped);

   always_comb begin
      result.matched = 1'b0;
      result.tier    = tfpr_pkg::TIER_NONE;
      result.score   = '0;
      if (pat_len == '0) begin
         result.matched = 1'b1;
         result.score   = tfpr_pkg::SCORE_W'(1);
      end else if (cursor_in == pat_len) begin
         result.matched = 1'b1;
         result.tier    = tier;
         result.score   = score_wide[tfpr_pkg::SCORE_W-1:0];
      end
   end

   // Advance per request; clear the per-path state after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff     <= '0;
         fuzzy_ff      <= '0;
         have_ff       <= 1'b0;
         prev_match_ff <= 1'b0;
         gap_ff        <= 1'b0;
         prev_byte_ff  <= '0;
         pos_ff        <= '0;
         hits_ff       <= '0;
      end else if (advance) begin
         if (last) begin
            cursor_ff     <= '0;
            fuzzy_ff      <= '0;
            have_ff       <= 1'b0;
            prev_match_ff <= 1'b0;
            gap_ff        <= 1'b0;
            prev_byte_ff  <= '0;
            pos_ff        <= '0;
            hits_ff       <= '0;
         end else begin
            cursor_ff     <= cursor_in;
            fuzzy_ff      <= fuzzy_in;
            have_ff       <= have_in;
            prev_match_ff <= prev_match_in;
            gap_ff        <= gap_in;
            prev_byte_ff  <= path_char;
            pos_ff        <= pos_in;
            hits_ff       <= hits_in;
         end
      end
   end

endmodule

>>> hdl/tiered_fuzzy_path_ranker_core.sv
// Tiered fuzzy path ranker: one path byte per request, one ranked result per path.
//
// Takes one path byte per clock cycle; a new request is accepted in every cycle unless
// a finished result sits in the output register and the receiver stalls it. Each byte
// passes through a row of MAX_PATTERN cells that hold the shift-and substring vector,
// one bit per cell handed to the right neighbour on each accepted byte, and through a
// greedy subsequence scorer. The result (matched, tier, score) of a path is registered
// in the cycle that accepts its last byte and is offered on the next cycle. The user must
// load the pattern through the csr port while idle; the block does not enforce this.
module tiered_fuzzy_path_ranker_core #(
   parameter int MAX_PATTERN = tfpr_pkg::MAX_PATTERN_DEF,
   parameter int LENGTH_CAP  = tfpr_pkg::LENGTH_CAP_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_path_byte,
   input  logic [tfpr_pkg::POS_W-1:0]         req_basename_start,
   input  logic                               req_last_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_matched,
   output logic [tfpr_pkg::TIER_W-1:0]        rsp_tier,
   output logic [tfpr_pkg::SCORE_W-1:0]       rsp_score,
   input  logic                               csr_write_enable,
   input  logic [tfpr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tfpr_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int CUR_W = $clog2(MAX_PATTERN + 1);
   localparam int IW    = tfpr_pkg::IDX_W;

   logic [tfpr_pkg::CSR_DATA_W-1:0]   pat_low_ff;
   logic [tfpr_pkg::CSR_DATA_W-1:0]   pat_high_ff;
   logic [tfpr_pkg::LEN_W-1:0]        pat_len_ff;
   logic [tfpr_pkg::PATTERN_W-1:0]    pattern;
   logic [IW-1:0]                     len_ext;
   logic [IW-1:0]                     eff_len;
   logic [CUR_W-1:0]                  pat_len;

   logic                              advance;
   logic [7:0]                        path_char;
   logic [MAX_PATTERN:0]              chain;
   logic [MAX_PATTERN-1:0]            cell_hit;
   tfpr_pkg::result_type              result;
   tfpr_pkg::result_type              rsp_ff;
   logic                              rsp_valid_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tfpr_pkg::CSR_PATTERN_LOW:    pat_low_ff  <= csr_write_data;
            tfpr_pkg::CSR_PATTERN_HIGH:   pat_high_ff <= csr_write_data;
            tfpr_pkg::CSR_PATTERN_LENGTH:
               pat_len_ff <= csr_write_data[tfpr_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the pattern length to the row size
   assign pattern = {pat_high_ff, pat_low_ff};
   assign len_ext = IW'(pat_len_ff);
   assign eff_len = (len_ext > IW'(MAX_PATTERN)) ? IW'(MAX_PATTERN) : len_ext;
   assign pat_len = eff_len[CUR_W-1:0];

   // Handshake: hold requests only while a result waits and is stalled
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign advance   = req_valid & ~req_stall;
   assign path_char = tfpr_pkg::lower_byte(req_path_byte);

   // Row of substring cells
   assign chain[0] = 1'b1;
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [7:0] pat_char;
      if (j < tfpr_pkg::PATTERN_BYTES) begin : g_stored
         assign pat_char = pattern[8*j +: 8];
      end else begin : g_blank
         assign pat_char = 8'h00;
      end
      tfpr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .clear     (req_last_byte),
         .enable    (eff_len > IW'(j)),
         .tail      (eff_len == IW'(j + 1)),
         .shift_in  (chain[j]),
         .pat_char  (pat_char),
         .path_char (path_char),
         .shift_out (chain[j+1]),
         .hit       (cell_hit[j])
      );
   end

   // Subsequence scorer and ranking
   tfpr_scorer #(
      .MAX_PATTERN (MAX_PATTERN),
      .LENGTH_CAP  (LENGTH_CAP)
   ) u_scorer (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .last           (req_last_byte),
      .path_char      (path_char),
      .basename_start (req_basename_start),
      .pattern        (pattern),
      .pat_len        (pat_len),
      .sub_hit        (|cell_hit),
      .result         (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_last_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_ff.matched;
   assign rsp_tier    = rsp_ff.tier;
   assign rsp_score   = rsp_ff.score;

endmodule

>>> hdl/tfpr_checker.sv
// Port-level checks of the ranker, bound to the top level.
`include "assert_macros.svh"

module tfpr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_last_byte,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_matched,
   input logic [tfpr_pkg::TIER_W-1:0]        rsp_tier,
   input logic [tfpr_pkg::SCORE_W-1:0]       rsp_score
);

   // Requests are held back only by a stalled result
   `TFPR_ASSERT_ALWAYS(a_stall_cause, req_stall |-> rsp_valid && rsp_stall,
                       "request stall without stalled result")

   // A final byte always yields a result on the next cycle
   `TFPR_ASSERT(a_result_follows, req_valid && !req_stall && req_last_byte |=> rsp_valid,
                "no result after final byte")

   // A new result only appears after a final byte
   `TFPR_ASSERT(a_result_cause,
                $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last_byte),
                "result without final byte")

   // An unmatched path carries no tier and no score
   `TFPR_ASSERT(a_unmatched_zero,
                rsp_valid && !rsp_matched |-> rsp_tier == tfpr_pkg::TIER_NONE && rsp_score == '0,
                "unmatched result not zero")

   // A stalled result holds its score
   `TFPR_ASSERT(a_score_hold, rsp_valid && rsp_stall |=> $stable(rsp_score),
                "stalled score changed")

endmodule

bind tiered_fuzzy_path_ranker_core tfpr_checker u_tfpr_checker (.*);

>>> tb/tiered_fuzzy_path_ranker_core_test.sv
// Self-checking testbench for the tiered fuzzy path ranker core.
module tiered_fuzzy_path_ranker_core_test;

   // One path byte as offered on the request channel
   typedef struct packed {
      logic [7:0]  path_byte;
      logic [15:0] basename_start;
      logic        last_byte;
   } path_request_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [7:0]                        req_path_byte = '0;
   logic [tfpr_pkg::POS_W-1:0]        req_basename_start = '0;
   logic                              req_last_byte = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_matched;
   logic [tfpr_pkg::TIER_W-1:0]       rsp_tier;
   logic [tfpr_pkg::SCORE_W-1:0]      rsp_score;
   logic                              csr_write_enable = 1'b0;
   logic [tfpr_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [tfpr_pkg::CSR_DATA_W-1:0]   csr_write_data = '0;

   // Request and result stores, run statistics
   path_request_type      path_q[$];
   path_request_type      next_request;
   tfpr_pkg::result_type  pending_ranks[$];
   tfpr_pkg::result_type  want_rank;
   tfpr_pkg::result_type  new_rank;
   bit            gaps_on = 1'b1;
   int            mismatches = 0;
   int            requests_sent = 0;
   int            paths_checked = 0;
   int            settings_used = 0;

   // Own copy of the pattern registers
   logic [63:0]   pat_lo_q = '0;
   logic [63:0]   pat_hi_q = '0;
   logic [4:0]    pat_len_q = '0;

   // Per-path ranking state
   int unsigned   cursor = 0;
   int            fuzzy_sum = 0;
   bit            matched_once = 1'b0;
   bit            prev_match = 1'b0;
   bit            gap_open = 1'b0;
   logic [7:0]    prev_byte = '0;
   int unsigned   position = 0;
   logic [15:0]   sub_vec = '0;
   logic [2:0]    hits = '0;

   tiered_fuzzy_path_ranker_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_path_byte      (req_path_byte),
      .req_basename_start (req_basename_start),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_matched        (rsp_matched),
      .rsp_tier           (rsp_tier),
      .rsp_score          (rsp_score),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Effective pattern length, clamped to the pattern store
   function automatic int unsigned pattern_span();
      return (pat_len_q > 5'd16) ? 16 : int'(pat_len_q);
   endfunction

   function automatic logic [7:0] pat_at(input int unsigned j);
      if (j < 8) begin
         return pat_lo_q[8*j +: 8];
      end
      if (j < 16) begin
         return pat_hi_q[8*(j-8) +: 8];
      end
      return 8'h00;
   endfunction

   // Add to the subsequence score, saturating at the bottom
   function automatic void add_fuzzy(input int d);
      fuzzy_sum = (fuzzy_sum + d < -131072) ? -131072 : fuzzy_sum + d;
   endfunction

   // Advance the ranking state by one path byte; return 1 with the rank on the last byte
   function automatic bit rank_byte(input logic [7:0] raw, input logic [15:0] bn_raw,
                                    input logic last, output tfpr_pkg::result_type rank);
      logic [7:0]  c;
      logic [15:0] cmask;
      int unsigned m, pos, bn, len, f, tier, j;
      bit          boundary;
      c = raw;
      if (c >= 8'h41 && c <= 8'h5A) begin
         c = c + 8'h20;
      end
      m = pattern_span();
      pos = position;
      bn = bn_raw;
      cmask = '0;
      rank = '0;
      if (m > 0) begin
         // greedy subsequence scoring
         if (cursor < m) begin
            if (c == pat_at(cursor)) begin
               boundary = (pos == 0) || prev_byte == 8'h2F || prev_byte == 8'h5F ||
                          prev_byte == 8'h2D || prev_byte == 8'h2E || prev_byte == 8'h20;
               add_fuzzy(16);
               if (boundary) begin
                  add_fuzzy(8);
               end
               if (cursor == 0 && pos >= bn) begin
                  add_fuzzy(8);
               end
               if (matched_once && prev_match) begin
                  add_fuzzy(4);
               end
               matched_once = 1'b1;
               prev_match = 1'b1;
               gap_open = 1'b0;
               cursor++;
            end else begin
               if (matched_once) begin
                  add_fuzzy(gap_open ? -1 : -3);
                  gap_open = 1'b1;
               end
               prev_match = 1'b0;
            end
         end
         // shift-and substring matching
         for (j = 0; j < m; j++) begin
            if (pat_at(j) == c) begin
               cmask[j] = 1'b1;
            end
         end
         sub_vec = ((sub_vec << 1) | 16'd1) & cmask;
         if (sub_vec[m-1]) begin
            hits[0] = 1'b1;
            if (pos + 1 >= bn + m) begin
               hits[1] = 1'b1;
            end
            if (pos + 1 == bn + m) begin
               hits[2] = 1'b1;
            end
         end
      end
      prev_byte = c;
      if (position < 65535) begin
         position++;
      end
      if (!last) begin
         return 1'b0;
      end
      // rank the finished path
      len = position;
      if (m == 0) begin
         rank.matched = 1'b1;
         rank.tier = tfpr_pkg::TIER_NONE;
         rank.score = 23'd1;
      end else if (cursor == m) begin
         if (hits[2] && len == bn + m) begin
            tier = tfpr_pkg::TIER_BASE_EXACT;
         end else if (hits[2]) begin
            tier = tfpr_pkg::TIER_BASE_PREFIX;
         end else if (hits[1]) begin
            tier = tfpr_pkg::TIER_BASE_SUB;
         end else if (hits[0]) begin
            tier = tfpr_pkg::TIER_PATH_SUB;
         end else begin
            tier = tfpr_pkg::TIER_SUBSEQUENCE;
         end
         f = (fuzzy_sum < 1) ? 1 : fuzzy_sum;
         if (len > 4096) begin
            len = 4096;
         end
         rank.matched = 1'b1;
         rank.tier = tfpr_pkg::tier_type'(tier);
         rank.score = tfpr_pkg::SCORE_W'(tier * tfpr_pkg::TIER_STEP + 8 * f - len);
      end
      cursor = 0;
      fuzzy_sum = 0;
      matched_once = 1'b0;
      prev_match = 1'b0;
      gap_open = 1'b0;
      prev_byte = '0;
      position = 0;
      sub_vec = '0;
      hits = '0;
      return 1'b1;
   endfunction

   // Request driver: hold a stalled request, otherwise offer the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (path_q.size() > 0 && !(gaps_on && $urandom_range(99) < 26)) begin
            next_request = path_q.pop_front();
            req_valid <= 1'b1;
            req_path_byte <= next_request.path_byte;
            req_basename_start <= next_request.basename_start;
            req_last_byte <= next_request.last_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: check each result, then predict from the accepted request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_ranks.size() == 0) begin
               $error("unexpected result: matched %0d tier %0d score %0d",
                      rsp_matched, rsp_tier, rsp_score);
               mismatches++;
            end else begin
               want_rank = pending_ranks.pop_front();
               paths_checked++;
               if (rsp_matched !== want_rank.matched) begin
                  $error("matched: expected %0d, got %0d", want_rank.matched, rsp_matched);
                  mismatches++;
               end
               if (rsp_tier !== want_rank.tier) begin
                  $error("tier: expected %0d, got %0d", want_rank.tier, rsp_tier);
                  mismatches++;
               end
               if (rsp_score !== want_rank.score) begin
                  $error("score: expected %0d, got %0d", want_rank.score, rsp_score);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            requests_sent++;
            if (rank_byte(req_path_byte, req_basename_start, req_last_byte, new_rank)) begin
               pending_ranks = {pending_ranks, new_rank};
            end
         end
         rsp_stall <= gaps_on && ($urandom_range(99) < 26);
      end
   end

   // Register write, returning at the following falling edge
   task automatic write_reg(input tfpr_pkg::csr_reg_type idx, input logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      case (idx)
         tfpr_pkg::CSR_PATTERN_LOW: begin
            pat_lo_q = data;
         end
         tfpr_pkg::CSR_PATTERN_HIGH: begin
            pat_hi_q = data;
         end
         default: begin
            pat_len_q = data[4:0];
         end
      endcase
   endtask

   task automatic load_pattern(input logic [127:0] bytes, input logic [4:0] len);
      write_reg(tfpr_pkg::CSR_PATTERN_LOW, bytes[63:0]);
      write_reg(tfpr_pkg::CSR_PATTERN_HIGH, bytes[127:64]);
      write_reg(tfpr_pkg::CSR_PATTERN_LENGTH, 64'(len));
      settings_used++;
   endtask

   task automatic set_pattern(input string s, input logic [4:0] len);
      logic [127:0] bytes;
      int           i;
      bytes = '0;
      for (i = 0; i < s.len() && i < 16; i++) begin
         bytes[8*i +: 8] = s[i];
      end
      load_pattern(bytes, len);
   endtask

   task automatic push_byte(input logic [7:0] b, input logic [15:0] bn, input logic last);
      path_request_type r;
      r.path_byte = b;
      r.basename_start = bn;
      r.last_byte = last;
      path_q = {path_q, r};
   endtask

   task automatic push_path(input string s, input logic [15:0] bn);
      int i;
      for (i = 0; i < s.len(); i++) begin
         push_byte(s[i], bn, i == s.len() - 1);
      end
   endtask

   // Wait until every request is taken and every rank has come back
   task automatic drain();
      do @(negedge clock);
      while (path_q.size() != 0 || req_valid || pending_ranks.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [7:0] filler_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) begin
         return 8'($urandom_range(8'h68, 8'h61));
      end
      if (r < 70) begin
         return 8'($urandom_range(8'h48, 8'h41));
      end
      if (r < 85) begin
         case ($urandom_range(3))
            0: return 8'h5F;
            1: return 8'h2D;
            2: return 8'h2E;
            default: return 8'h20;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   // Pattern byte, sometimes raised to capitals
   function automatic logic [7:0] cased(input logic [7:0] b);
      if (b >= 8'h61 && b <= 8'h7A && $urandom_range(3) == 0) begin
         return b - 8'h20;
      end
      return b;
   endfunction

   // Build one path shaped to reach a chosen tier, or noise
   task automatic queue_random_path(output int unsigned count);
      logic [7:0]  bytes[$];
      int unsigned mode, m, dirs, bn, i, j;
      m = pattern_span();
      mode = $urandom_range(9);
      dirs = (mode == 3) ? $urandom_range(3, 1) : $urandom_range(3);
      for (i = 0; i < dirs; i++) begin
         repeat ($urandom_range(4, 1)) bytes = {bytes, filler_byte()};
         if (mode == 3 && i == dirs - 1) begin
            for (j = 0; j < m; j++) begin
               bytes = {bytes, cased(pat_at(j))};
            end
         end
         bytes = {bytes, 8'h2F};
      end
      bn = bytes.size();
      case (mode)
         0, 8: begin
            for (j = 0; j < m; j++) bytes = {bytes, cased(pat_at(j))};
         end
         1: begin
            for (j = 0; j < m; j++) bytes = {bytes, cased(pat_at(j))};
            repeat ($urandom_range(5, 1)) bytes = {bytes, filler_byte()};
         end
         2: begin
            repeat ($urandom_range(4, 1)) bytes = {bytes, filler_byte()};
            for (j = 0; j < m; j++) bytes = {bytes, cased(pat_at(j))};
            repeat ($urandom_range(4)) bytes = {bytes, filler_byte()};
         end
         4, 9: begin
            for (j = 0; j < m; j++) begin
               repeat ($urandom_range(3)) bytes = {bytes, filler_byte()};
               bytes = {bytes, cased(pat_at(j))};
            end
         end
         7: begin
            repeat ($urandom_range(20, 1)) bytes = {bytes, 8'($urandom_range(255))};
         end
         default: begin
            repeat ($urandom_range(12, 1)) bytes = {bytes, filler_byte()};
         end
      endcase
      if (bytes.size() == 0) begin
         bytes = {bytes, filler_byte()};
      end
      if (mode == 8) begin
         bn = $urandom_range(16'hFFFF);
      end else if (mode == 9) begin
         bn = $urandom_range(bytes.size() + 1);
      end
      for (i = 0; i < bytes.size(); i++) begin
         push_byte(bytes[i], (mode == 7) ? 16'($urandom_range(16'hFFFF)) : 16'(bn),
                   i == bytes.size() - 1);
      end
      count = bytes.size();
   endtask

   // Random pattern of letters, or of any byte values
   task automatic random_pattern(input logic [4:0] len, input bit any_byte);
      logic [127:0] bytes;
      int           i;
      for (i = 0; i < 16; i++) begin
         bytes[8*i +: 8] = any_byte ? 8'($urandom_range(255)) : 8'($urandom_range(8'h68, 8'h61));
      end
      if (!any_byte && $urandom_range(3) == 0) begin
         i = $urandom_range(15);
         bytes[8*i +: 8] = 8'h43;
      end
      load_pattern(bytes, len);
   endtask

   // Stimulus sequence
   initial begin
      int unsigned phase, phase_items, count;
      int          i;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty query straight after reset
      push_path("A", 16'd0);
      drain();

      // several tiers, word boundaries with capitals, no match, basename past the end
      set_pattern("foo", 5'd3);
      push_path("a/foo", 16'd2);
      push_path("Fo_O", 16'd0);
      push_path("zz", 16'd0);
      push_path("foo", 16'hFFFF);
      drain();

      // capitals in the pattern never match
      set_pattern("Ab", 5'd2);
      push_path("ab", 16'd0);
      drain();

      // all-ones pattern with an overlong length, zero bytes
      load_pattern('1, 5'd31);
      for (i = 0; i < 16; i++) begin
         push_byte(8'hFF, 16'd0, i == 15);
      end
      push_byte(8'h00, 16'd0, 1'b0);
      push_byte(8'h00, 16'hFFFF, 1'b1);
      drain();

      // long gap drives the fuzzy sum below one so the floor applies
      gaps_on = 1'b0;
      set_pattern("aq", 5'd2);
      push_byte(8'h61, 16'd0, 1'b0);
      for (i = 0; i < 60; i++) begin
         push_byte(8'h78, 16'd0, 1'b0);
      end
      push_byte(8'h71, 16'd0, 1'b1);
      drain();
      gaps_on = 1'b1;

      // random phases over several pattern settings
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: random_pattern(5'd16, 1'b0);
            1: random_pattern(5'd1, 1'b0);
            2: random_pattern(5'd0, 1'b1);
            3: random_pattern(5'd31, 1'b0);
            4: random_pattern(5'd17, 1'b0);
            5: random_pattern(5'($urandom_range(16, 1)), 1'b1);
            default: random_pattern(5'($urandom_range(8, 2)), 1'b0);
         endcase
         // one phase runs without any idling on either side
         gaps_on = (phase != 4);
         phase_items = 0;
         while (phase_items < 190) begin
            queue_random_path(count);
            phase_items += count;
         end
         drain();
      end

      $display("%0d path bytes sent, %0d ranked paths checked over %0d pattern settings",
               requests_sent, paths_checked, settings_used);
      if (mismatches == 0) begin
         $display("tiered_fuzzy_path_ranker_core_test: clean");
      end else begin
         $display("tiered_fuzzy_path_ranker_core_test: errors");
      end
      $finish;
   end

   // Give up on a hung run
   initial begin
      #20000000;
      $display("timeout with %0d ranks outstanding", pending_ranks.size());
      $display("tiered_fuzzy_path_ranker_core_test: errors");
      $finish;
   end

endmodule
